FILE: design/ppl_pkg.sv
// Shared types, constants and codes for the page pool LRU manager.
`default_nettype none
package ppl_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int PIN_BITS  = 8;
    localparam int IDX_W     = $clog2(POOL_DEPTH);
    localparam int PTR_W     = IDX_W + 1;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = PTR_W;
    localparam int TOT_W     = 32;
    localparam int META_W    = PIN_BITS + 1;

    localparam logic [PTR_W-1:0]    NIL     = {1'b1, {IDX_W{1'b0}}};
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
    localparam logic [CFG_W-1:0]    POOL_RESET = CFG_W'(POOL_DEPTH);

    typedef enum logic [2:0] {
        FN_ALLOC  = 3'd0,
        FN_FREE   = 3'd1,
        FN_TOUCH  = 3'd2,
        FN_PIN    = 3'd3,
        FN_UNPIN  = 3'd4,
        FN_EVICT  = 3'd5,
        FN_REINIT = 3'd6,
        FN_NOP    = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_BAD_INDEX  = 3'd2,
        ST_PINNED     = 3'd3,
        ST_NOT_ALLOC  = 3'd4,
        ST_PIN_SAT    = 3'd5,
        ST_NOT_PINNED = 3'd6,
        ST_NONE_EVICT = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_CHECK,
        S_TOUCH2,
        S_PREV_FIX,
        S_WALK,
        S_RESP
    } state_t;

    typedef struct packed {
        func_t            func;
        logic [IDX_W-1:0] page;
    } in_t;

    typedef struct packed {
        logic [CNT_W-1:0] free_cnt;
        logic [CNT_W-1:0] used_cnt;
        logic [CNT_W-1:0] pinned_cnt;
        logic [TOT_W-1:0] alloc_total;
        logic [TOT_W-1:0] free_total;
        logic [TOT_W-1:0] evict_total;
        logic [TOT_W-1:0] touch_total;
    } stats_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] page_out;
        logic [CNT_W-1:0] free_cnt;
        logic [CNT_W-1:0] used_cnt;
        logic [CNT_W-1:0] pinned_cnt;
        logic [TOT_W-1:0] alloc_total;
        logic [TOT_W-1:0] free_total;
        logic [TOT_W-1:0] evict_total;
        logic [TOT_W-1:0] touch_total;
    } out_t;

    typedef struct packed {
        logic             init;
        logic [CNT_W-1:0] init_pages;
        logic             alloc;
        logic             free;
        logic             pin_up;
        logic             pin_dn;
        logic             evict;
        logic             touch;
    } stat_upd_t;

endpackage
`default_nettype wire

FILE: design/ppl_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module ppl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/ppl_stats.sv
// Occupancy counters and wrapping operation totals.
`default_nettype none
module ppl_stats (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ppl_pkg::stat_upd_t upd,
    output ppl_pkg::stats_t         stats
);

    ppl_pkg::stats_t stats_reg;
    ppl_pkg::stats_t stats_next;

    always_comb begin
        stats_next = stats_reg;
        if (upd.init) begin
            stats_next.free_cnt   = upd.init_pages;
            stats_next.used_cnt   = '0;
            stats_next.pinned_cnt = '0;
        end
        if (upd.alloc) begin
            stats_next.free_cnt    = stats_reg.free_cnt - 1'b1;
            stats_next.used_cnt    = stats_reg.used_cnt + 1'b1;
            stats_next.alloc_total = stats_reg.alloc_total + 1'b1;
        end
        if (upd.free) begin
            stats_next.free_cnt   = stats_reg.free_cnt + 1'b1;
            stats_next.used_cnt   = stats_reg.used_cnt - 1'b1;
            stats_next.free_total = stats_reg.free_total + 1'b1;
        end
        if (upd.pin_up) begin
            stats_next.pinned_cnt = stats_reg.pinned_cnt + 1'b1;
        end
        if (upd.pin_dn) begin
            stats_next.pinned_cnt = stats_reg.pinned_cnt - 1'b1;
        end
        if (upd.evict) begin
            stats_next.evict_total = stats_reg.evict_total + 1'b1;
        end
        if (upd.touch) begin
            stats_next.touch_total = stats_reg.touch_total + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= '{free_cnt: ppl_pkg::CNT_W'(ppl_pkg::POOL_DEPTH), default: '0};
        end else begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule
`default_nettype wire

FILE: design/page_pool_lru_manager.sv
// Top level: page pool with free list, LRU list, pin counts and sequencer.
//
// Input beats (s_valid/s_ready) carry a function code and a page index; each
// accepted beat yields exactly one result beat on m_valid/m_ready with the
// status, the page, occupancy after the operation and the wrapping totals.
// One operation is in flight at a time; s_ready is high only while idle.
// From accept, a bad index, an empty free list, an empty LRU list and unused
// codes go straight to S_RESP; pin, unpin, free and any page not allocated
// pass through S_CHECK; alloc passes through S_ALLOC and S_PREV_FIX (S_ALLOC
// alone into an empty LRU list); touch passes through S_CHECK, S_TOUCH2 and
// S_PREV_FIX (S_CHECK alone when the page is already most recent); evict
// stays in S_WALK while it skips pinned pages. The steps are set by the
// dependent reads of the link memories (one registered read per cycle) and,
// for reinit, by the sweep that rewrites one entry a cycle. Back to back
// operations start in the cycle after the result loads. After reset the
// same sweep covers all POOL_DEPTH (1024) entries with s_ready low; cfg_we
// is honored throughout and pool_pages takes effect at reinit. A stalled
// result sits in the output register; the next beat may be accepted and
// worked on meanwhile, and its result waits until the first one is taken.
`default_nettype none
module page_pool_lru_manager (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [ppl_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ppl_pkg::in_t                  s_payload,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ppl_pkg::out_t                      m_payload
);

    localparam int IW = ppl_pkg::IDX_W;
    localparam int PW = ppl_pkg::PTR_W;
    localparam int PB = ppl_pkg::PIN_BITS;
    localparam int MW = ppl_pkg::META_W;

    ppl_pkg::state_t  state_reg, state_next;
    ppl_pkg::in_t     cmd_reg, cmd_next;
    logic [ppl_pkg::CFG_W-1:0] pool_pages_reg;
    logic [PW-1:0]    pool_active_reg, pool_active_next;
    logic [PW-1:0]    clr_idx_reg, clr_idx_next;
    logic             reinit_reg, reinit_next;
    logic [PW-1:0]    free_top_reg, free_top_next;
    logic [PW-1:0]    recent_reg, recent_next;
    logic [PW-1:0]    stale_reg, stale_next;
    logic [PW-1:0]    cur_reg, cur_next;
    logic [PW-1:0]    fix_reg, fix_next;
    ppl_pkg::status_t res_status_reg, res_status_next;
    logic [IW-1:0]    res_page_reg, res_page_next;
    logic             m_valid_reg, m_valid_next;
    ppl_pkg::out_t    m_payload_reg, m_payload_next;

    logic [IW-1:0] rd_addr;
    logic          fn_we, meta_we, prev_we, next_we;
    logic [IW-1:0] fn_waddr, meta_waddr, prev_waddr, next_waddr;
    logic [PW-1:0] fn_wdata, prev_wdata, next_wdata;
    logic [MW-1:0] meta_wdata;
    logic [PW-1:0] fn_rdata, prev_rdata, next_rdata;
    logic [MW-1:0] meta_rdata;

    ppl_pkg::stat_upd_t upd;
    ppl_pkg::stats_t    stats;

    logic             accept;
    logic             needs_page;
    logic             bad_index;
    logic [PW-1:0]    pool_clamped;
    logic             meta_used;
    logic [PB-1:0]    meta_pin;
    logic             load_out;
    logic [PW-1:0]    cmd_ptr;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ppl_pkg::S_IDLE);
    assign needs_page = (s_payload.func == ppl_pkg::FN_FREE)  ||
                        (s_payload.func == ppl_pkg::FN_TOUCH) ||
                        (s_payload.func == ppl_pkg::FN_PIN)   ||
                        (s_payload.func == ppl_pkg::FN_UNPIN);
    assign bad_index  = needs_page && ({1'b0, s_payload.page} >= pool_active_reg);
    assign meta_used  = meta_rdata[PB];
    assign meta_pin   = meta_rdata[PB-1:0];
    assign load_out   = (state_reg == ppl_pkg::S_RESP) && (!m_valid_reg || m_ready);
    assign cmd_ptr    = {1'b0, cmd_reg.page};

    always_comb begin
        if (pool_pages_reg == '0) begin
            pool_clamped = PW'(1);
        end else if (pool_pages_reg > ppl_pkg::CFG_W'(ppl_pkg::POOL_DEPTH)) begin
            pool_clamped = PW'(ppl_pkg::POOL_DEPTH);
        end else begin
            pool_clamped = PW'(pool_pages_reg);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppl_pkg::S_CLEAR: begin
                if (clr_idx_reg == PW'(ppl_pkg::POOL_DEPTH - 1)) begin
                    state_next = reinit_reg ? ppl_pkg::S_RESP : ppl_pkg::S_IDLE;
                end
            end
            ppl_pkg::S_IDLE: begin
                if (accept) begin
                    if (bad_index) begin
                        state_next = ppl_pkg::S_RESP;
                    end else begin
                        case (s_payload.func)
                            ppl_pkg::FN_ALLOC: state_next = free_top_reg[PW-1] ?
                                ppl_pkg::S_RESP : ppl_pkg::S_ALLOC;
                            ppl_pkg::FN_FREE, ppl_pkg::FN_TOUCH,
                            ppl_pkg::FN_PIN, ppl_pkg::FN_UNPIN:
                                state_next = ppl_pkg::S_CHECK;
                            ppl_pkg::FN_EVICT: state_next = stale_reg[PW-1] ?
                                ppl_pkg::S_RESP : ppl_pkg::S_WALK;
                            ppl_pkg::FN_REINIT: state_next = ppl_pkg::S_CLEAR;
                            default: state_next = ppl_pkg::S_RESP;
                        endcase
                    end
                end
            end
            ppl_pkg::S_ALLOC: begin
                state_next = recent_reg[PW-1] ? ppl_pkg::S_RESP : ppl_pkg::S_PREV_FIX;
            end
            ppl_pkg::S_CHECK: begin
                if (meta_used && cmd_reg.func == ppl_pkg::FN_TOUCH &&
                    recent_reg != cmd_ptr) begin
                    state_next = ppl_pkg::S_TOUCH2;
                end else begin
                    state_next = ppl_pkg::S_RESP;
                end
            end
            ppl_pkg::S_TOUCH2:   state_next = ppl_pkg::S_PREV_FIX;
            ppl_pkg::S_PREV_FIX: state_next = ppl_pkg::S_RESP;
            ppl_pkg::S_WALK: begin
                if (meta_pin == '0 || prev_rdata[PW-1]) begin
                    state_next = ppl_pkg::S_RESP;
                end
            end
            ppl_pkg::S_RESP: begin
                if (load_out) begin
                    state_next = ppl_pkg::S_IDLE;
                end
            end
            default: state_next = ppl_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        cmd_next         = cmd_reg;
        pool_active_next = pool_active_reg;
        clr_idx_next     = clr_idx_reg;
        reinit_next      = reinit_reg;
        free_top_next    = free_top_reg;
        recent_next      = recent_reg;
        stale_next       = stale_reg;
        cur_next         = cur_reg;
        fix_next         = fix_reg;
        res_status_next  = res_status_reg;
        res_page_next    = res_page_reg;
        rd_addr          = s_payload.page;
        fn_we      = 1'b0;  fn_waddr   = '0;  fn_wdata   = '0;
        meta_we    = 1'b0;  meta_waddr = '0;  meta_wdata = '0;
        prev_we    = 1'b0;  prev_waddr = '0;  prev_wdata = '0;
        next_we    = 1'b0;  next_waddr = '0;  next_wdata = '0;
        upd        = '0;
        upd.init_pages = pool_clamped;

        unique case (state_reg)
            ppl_pkg::S_CLEAR: begin
                fn_we      = 1'b1;
                fn_waddr   = clr_idx_reg[IW-1:0];
                fn_wdata   = ((clr_idx_reg + 1'b1) < pool_active_reg) ?
                             clr_idx_reg + 1'b1 : ppl_pkg::NIL;
                meta_we    = 1'b1;
                meta_waddr = clr_idx_reg[IW-1:0];
                meta_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ppl_pkg::S_IDLE: begin
                if (s_payload.func == ppl_pkg::FN_ALLOC) begin
                    rd_addr = free_top_reg[IW-1:0];
                end else if (s_payload.func == ppl_pkg::FN_EVICT) begin
                    rd_addr = stale_reg[IW-1:0];
                end
                if (accept) begin
                    cmd_next        = s_payload;
                    res_page_next   = s_payload.page;
                    res_status_next = ppl_pkg::ST_OK;
                    cur_next        = stale_reg;
                    if (bad_index) begin
                        res_status_next = ppl_pkg::ST_BAD_INDEX;
                    end else if (s_payload.func == ppl_pkg::FN_ALLOC && free_top_reg[PW-1]) begin
                        res_status_next = ppl_pkg::ST_NO_FREE;
                    end else if (s_payload.func == ppl_pkg::FN_EVICT && stale_reg[PW-1]) begin
                        res_status_next = ppl_pkg::ST_NONE_EVICT;
                    end else if (s_payload.func == ppl_pkg::FN_REINIT) begin
                        pool_active_next = pool_clamped;
                        clr_idx_next     = '0;
                        reinit_next      = 1'b1;
                        free_top_next    = '0;
                        recent_next      = ppl_pkg::NIL;
                        stale_next       = ppl_pkg::NIL;
                        upd.init         = 1'b1;
                    end
                end
            end
            ppl_pkg::S_ALLOC: begin
                free_top_next = fn_rdata;
                fn_we      = 1'b1;
                fn_waddr   = free_top_reg[IW-1:0];
                fn_wdata   = ppl_pkg::NIL;
                meta_we    = 1'b1;
                meta_waddr = free_top_reg[IW-1:0];
                meta_wdata = {1'b1, {PB{1'b0}}};
                next_we    = 1'b1;
                next_waddr = free_top_reg[IW-1:0];
                next_wdata = recent_reg;
                prev_we    = 1'b1;
                prev_waddr = free_top_reg[IW-1:0];
                prev_wdata = ppl_pkg::NIL;
                res_page_next = free_top_reg[IW-1:0];
                fix_next      = recent_reg;
                recent_next   = free_top_reg;
                if (stale_reg[PW-1]) begin
                    stale_next = free_top_reg;
                end
                upd.alloc = 1'b1;
            end
            ppl_pkg::S_CHECK: begin
                if (!meta_used) begin
                    res_status_next = ppl_pkg::ST_NOT_ALLOC;
                end else begin
                    case (cmd_reg.func)
                        ppl_pkg::FN_FREE: begin
                            if (meta_pin != '0) begin
                                res_status_next = ppl_pkg::ST_PINNED;
                            end else begin
                                if (!prev_rdata[PW-1]) begin
                                    next_we    = 1'b1;
                                    next_waddr = prev_rdata[IW-1:0];
                                    next_wdata = next_rdata;
                                end else begin
                                    recent_next = next_rdata;
                                end
                                if (!next_rdata[PW-1]) begin
                                    prev_we    = 1'b1;
                                    prev_waddr = next_rdata[IW-1:0];
                                    prev_wdata = prev_rdata;
                                end else begin
                                    stale_next = prev_rdata;
                                end
                                meta_we       = 1'b1;
                                meta_waddr    = cmd_reg.page;
                                meta_wdata    = '0;
                                fn_we         = 1'b1;
                                fn_waddr      = cmd_reg.page;
                                fn_wdata      = free_top_reg;
                                free_top_next = cmd_ptr;
                                upd.free      = 1'b1;
                            end
                        end
                        ppl_pkg::FN_TOUCH: begin
                            upd.touch = 1'b1;
                            if (recent_reg != cmd_ptr) begin
                                next_we    = 1'b1;
                                next_waddr = prev_rdata[IW-1:0];
                                next_wdata = next_rdata;
                                if (!next_rdata[PW-1]) begin
                                    prev_we    = 1'b1;
                                    prev_waddr = next_rdata[IW-1:0];
                                    prev_wdata = prev_rdata;
                                end else begin
                                    stale_next = prev_rdata;
                                end
                            end
                        end
                        ppl_pkg::FN_PIN: begin
                            if (meta_pin == ppl_pkg::PIN_MAX) begin
                                res_status_next = ppl_pkg::ST_PIN_SAT;
                            end else begin
                                meta_we    = 1'b1;
                                meta_waddr = cmd_reg.page;
                                meta_wdata = {1'b1, meta_pin + 1'b1};
                                upd.pin_up = (meta_pin == '0);
                            end
                        end
                        ppl_pkg::FN_UNPIN: begin
                            if (meta_pin == '0) begin
                                res_status_next = ppl_pkg::ST_NOT_PINNED;
                            end else begin
                                meta_we    = 1'b1;
                                meta_waddr = cmd_reg.page;
                                meta_wdata = {1'b1, meta_pin - 1'b1};
                                upd.pin_dn = (meta_pin == PB'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ppl_pkg::S_TOUCH2: begin
                next_we     = 1'b1;
                next_waddr  = cmd_reg.page;
                next_wdata  = recent_reg;
                prev_we     = 1'b1;
                prev_waddr  = cmd_reg.page;
                prev_wdata  = ppl_pkg::NIL;
                fix_next    = recent_reg;
                recent_next = cmd_ptr;
            end
            ppl_pkg::S_PREV_FIX: begin
                prev_we    = 1'b1;
                prev_waddr = fix_reg[IW-1:0];
                prev_wdata = {1'b0, res_page_reg};
            end
            ppl_pkg::S_WALK: begin
                rd_addr = prev_rdata[IW-1:0];
                if (meta_pin == '0) begin
                    res_page_next   = cur_reg[IW-1:0];
                    res_status_next = ppl_pkg::ST_OK;
                    upd.evict       = 1'b1;
                end else if (prev_rdata[PW-1]) begin
                    res_status_next = ppl_pkg::ST_NONE_EVICT;
                end else begin
                    cur_next = prev_rdata;
                end
            end
            ppl_pkg::S_RESP: begin
                reinit_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (load_out) begin
            m_valid_next                = 1'b1;
            m_payload_next.status       = res_status_reg;
            m_payload_next.page_out     = res_page_reg;
            m_payload_next.free_cnt     = stats.free_cnt;
            m_payload_next.used_cnt     = stats.used_cnt;
            m_payload_next.pinned_cnt   = stats.pinned_cnt;
            m_payload_next.alloc_total  = stats.alloc_total;
            m_payload_next.free_total   = stats.free_total;
            m_payload_next.evict_total  = stats.evict_total;
            m_payload_next.touch_total  = stats.touch_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ppl_pkg::S_CLEAR;
            pool_pages_reg  <= ppl_pkg::POOL_RESET;
            pool_active_reg <= PW'(ppl_pkg::POOL_DEPTH);
            clr_idx_reg     <= '0;
            reinit_reg      <= 1'b0;
            free_top_reg    <= '0;
            recent_reg      <= ppl_pkg::NIL;
            stale_reg       <= ppl_pkg::NIL;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_we) begin
                pool_pages_reg <= cfg_wdata;
            end
            pool_active_reg <= pool_active_next;
            clr_idx_reg     <= clr_idx_next;
            reinit_reg      <= reinit_next;
            free_top_reg    <= free_top_next;
            recent_reg      <= recent_next;
            stale_reg       <= stale_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        cur_reg        <= cur_next;
        fix_reg        <= fix_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        m_payload_reg  <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    ppl_ram #(.WIDTH(PW), .DEPTH(ppl_pkg::POOL_DEPTH)) u_free_next (
        .aclk(aclk), .we(fn_we), .waddr(fn_waddr), .wdata(fn_wdata),
        .raddr(rd_addr), .rdata(fn_rdata)
    );

    ppl_ram #(.WIDTH(MW), .DEPTH(ppl_pkg::POOL_DEPTH)) u_meta (
        .aclk(aclk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(rd_addr), .rdata(meta_rdata)
    );

    ppl_ram #(.WIDTH(PW), .DEPTH(ppl_pkg::POOL_DEPTH)) u_lru_prev (
        .aclk(aclk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(rd_addr), .rdata(prev_rdata)
    );

    ppl_ram #(.WIDTH(PW), .DEPTH(ppl_pkg::POOL_DEPTH)) u_lru_next (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(rd_addr), .rdata(next_rdata)
    );

    ppl_stats u_stats (
        .aclk(aclk), .aresetn(aresetn), .upd(upd), .stats(stats)
    );

    a_occ_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, stats.free_cnt} + {1'b0, stats.used_cnt}) == {1'b0, pool_active_reg})
        else $error("free plus used pages differ from pool size");

    a_pinned_le_used: assert property (@(posedge aclk) disable iff (!aresetn)
        stats.pinned_cnt <= stats.used_cnt)
        else $error("pinned pages exceed used pages");

    a_free_top: assert property (@(posedge aclk) disable iff (!aresetn)
        free_top_reg[PW-1] == (stats.free_cnt == '0))
        else $error("free list head disagrees with free count");

    a_lru_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        recent_reg[PW-1] == stale_reg[PW-1])
        else $error("LRU ends disagree on empty list");

endmodule
`default_nettype wire
